// ===== rtl/iac_pkg.sv =====
package iac_pkg;

    // Configuration register indexes on the write channel.
    typedef enum logic [1:0] {
        CFG_MASTER_PIN   = 2'd0,
        CFG_ENTRY_DELAY  = 2'd1,
        CFG_PULSE_PERIOD = 2'd2,
        CFG_PULSE_STEP   = 2'd3
    } cfg_index_t;

    // Event kinds carried in tuser.
    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_BUTTON  = 2'd1,
        MODE_MESSAGE = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    // Commands carried by a message.
    typedef enum logic [1:0] {
        CMD_NONE       = 2'd0,
        CMD_ACTIVATE   = 2'd1,
        CMD_DEACTIVATE = 2'd2,
        CMD_RESET_PIN  = 2'd3
    } command_t;

    // Notification codes.
    localparam logic [1:0] NOTIFY_NONE      = 2'd0;
    localparam logic [1:0] NOTIFY_MOTION    = 2'd1;
    localparam logic [1:0] NOTIFY_INTRUSION = 2'd2;
    localparam logic [1:0] NOTIFY_WRONG_PIN = 2'd3;

    // Display screen codes.
    localparam logic [2:0] SCREEN_UNCHANGED = 3'd0;
    localparam logic [2:0] SCREEN_ARMED     = 3'd1;
    localparam logic [2:0] SCREEN_DISARMED  = 3'd2;
    localparam logic [2:0] SCREEN_GRANTED   = 3'd3;
    localparam logic [2:0] SCREEN_MOTION    = 3'd4;
    localparam logic [2:0] SCREEN_INTRUSION = 3'd5;
    localparam logic [2:0] SCREEN_RETRY     = 3'd6;
    localparam logic [2:0] SCREEN_WARNED    = 3'd7;

    // Register reset values.
    localparam logic [13:0] MASTER_PIN_RESET   = 14'd1981;
    localparam logic [19:0] ENTRY_DELAY_RESET  = 20'd10000;
    localparam logic [7:0]  PULSE_PERIOD_RESET = 8'd5;
    localparam logic [6:0]  PULSE_STEP_RESET   = 7'd5;

    // Siren pulse limits.
    localparam logic signed [9:0] PULSE_TOP    = 10'sd255;
    localparam logic signed [9:0] BUZZER_LEVEL = 10'sd150;
    localparam logic signed [10:0] PULSE_MAX   = 11'sd511;
    localparam logic signed [10:0] PULSE_MIN   = -11'sd512;

    // LED colors.
    localparam logic [7:0] LED_FULL = 8'hFF;
    localparam logic [7:0] LED_DARK = 8'h00;

    typedef struct packed {
        logic [13:0] master_pin;
        logic [19:0] entry_delay_ms;
        logic [7:0]  pulse_period_ticks;
        logic [6:0]  pulse_step;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        command_t    command;
        logic [13:0] pin_value;
        logic        violation;
    } item_t;

    typedef struct packed {
        logic [1:0] system_state;
        logic [7:0] led_red;
        logic [7:0] led_green;
        logic [7:0] led_blue;
        logic       lamp_blink;
        logic       buzzer_on;
        logic [1:0] notify_code;
        logic [2:0] screen_code;
    } result_t;

endpackage

// ===== rtl/iac_fsm.sv =====
module iac_fsm import iac_pkg::*; #(
    parameter int TIMER_BITS = 20
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    localparam int CMP_W = (TIMER_BITS > 20) ? TIMER_BITS : 20;

    typedef enum logic [1:0] {
        ST_OFF   = 2'd0,
        ST_ARMED = 2'd1,
        ST_PRE   = 2'd2,
        ST_INTR  = 2'd3
    } alarm_state_t;

    alarm_state_t           alarm_state_reg,     alarm_state_next;
    logic [TIMER_BITS-1:0]  entry_timer_reg,     entry_timer_next;
    logic [1:0]             wrong_pin_count_reg, wrong_pin_count_next;
    logic                   notified_flag_reg,   notified_flag_next;
    logic signed [9:0]      pulse_level_reg,     pulse_level_next;
    logic                   pulse_falling_reg,   pulse_falling_next;
    logic [7:0]             pulse_prescaler_reg, pulse_prescaler_next;
    logic [7:0]             led_red_reg,         led_red_next;
    logic [7:0]             led_green_reg,       led_green_next;
    logic [7:0]             led_blue_reg,        led_blue_next;
    logic [1:0]             notify;
    logic [2:0]             screen;

    // Next state and result for the item at the head of the pipe.
    always_comb begin
        logic [7:0]         period;
        logic signed [10:0] sum;
        logic signed [10:0] step_ext;
        logic               fire;

        alarm_state_next     = alarm_state_reg;
        entry_timer_next     = entry_timer_reg;
        wrong_pin_count_next = wrong_pin_count_reg;
        notified_flag_next   = notified_flag_reg;
        pulse_level_next     = pulse_level_reg;
        pulse_falling_next   = pulse_falling_reg;
        pulse_prescaler_next = pulse_prescaler_reg;
        led_red_next         = led_red_reg;
        led_green_next       = led_green_reg;
        led_blue_next        = led_blue_reg;
        notify               = NOTIFY_NONE;
        screen               = SCREEN_UNCHANGED;
        fire                 = 1'b0;
        period   = (cfg.pulse_period_ticks == 8'd0) ? 8'd1 : cfg.pulse_period_ticks;
        step_ext = signed'({4'b0000, cfg.pulse_step});
        sum      = '0;

        unique case (item.mode)
            MODE_TICK: begin
                // Entry delay count in pre-alarm, saturating at the timer's top.
                if (alarm_state_reg == ST_PRE) begin
                    if (!(&entry_timer_reg)) begin
                        entry_timer_next = entry_timer_reg + TIMER_BITS'(1);
                    end
                    if (CMP_W'(entry_timer_next) >= CMP_W'(cfg.entry_delay_ms)) begin
                        fire = 1'b1;
                    end
                end
                if (fire) begin
                    alarm_state_next = ST_INTR;
                    if (notified_flag_reg) begin
                        notify             = NOTIFY_INTRUSION;
                        notified_flag_next = 1'b0;
                    end
                    screen = SCREEN_INTRUSION;
                end
                // Siren pulse prescaler and triangle step.
                if (alarm_state_next == ST_INTR) begin
                    pulse_prescaler_next = pulse_prescaler_reg + 8'd1;
                    if (pulse_prescaler_next >= period) begin
                        pulse_prescaler_next = 8'd0;
                        sum = pulse_falling_reg ? (11'(pulse_level_reg) - step_ext)
                                                : (11'(pulse_level_reg) + step_ext);
                        if (sum > PULSE_MAX) begin
                            sum = PULSE_MAX;
                        end
                        if (sum < PULSE_MIN) begin
                            sum = PULSE_MIN;
                        end
                        pulse_level_next = sum[9:0];
                        if (pulse_level_next >= PULSE_TOP || pulse_level_next <= 10'sd0) begin
                            pulse_falling_next = !pulse_falling_reg;
                        end
                    end
                end
            end
            MODE_BUTTON: begin
                if (alarm_state_reg == ST_INTR || alarm_state_reg == ST_PRE) begin
                    alarm_state_next   = ST_ARMED;
                    notified_flag_next = 1'b0;
                    led_red_next       = LED_DARK;
                    led_green_next     = LED_FULL;
                    led_blue_next      = LED_DARK;
                    screen             = SCREEN_ARMED;
                end
            end
            MODE_MESSAGE: begin
                // Command first.
                unique case (item.command)
                    CMD_ACTIVATE: begin
                        alarm_state_next   = ST_ARMED;
                        notified_flag_next = 1'b0;
                        led_red_next       = LED_DARK;
                        led_green_next     = LED_FULL;
                        led_blue_next      = LED_DARK;
                        screen             = SCREEN_ARMED;
                    end
                    CMD_DEACTIVATE: begin
                        alarm_state_next   = ST_OFF;
                        notified_flag_next = 1'b0;
                        led_red_next       = LED_DARK;
                        led_green_next     = LED_DARK;
                        led_blue_next      = LED_DARK;
                        screen             = SCREEN_DISARMED;
                    end
                    CMD_RESET_PIN: begin
                        if (alarm_state_reg == ST_INTR || alarm_state_reg == ST_PRE) begin
                            if (item.pin_value == cfg.master_pin) begin
                                alarm_state_next     = ST_ARMED;
                                notified_flag_next   = 1'b0;
                                wrong_pin_count_next = 2'd0;
                                led_red_next         = LED_DARK;
                                led_green_next       = LED_FULL;
                                led_blue_next        = LED_DARK;
                                screen               = SCREEN_GRANTED;
                            end else if (alarm_state_reg == ST_PRE) begin
                                alarm_state_next = ST_INTR;
                                if (notified_flag_reg) begin
                                    notify             = NOTIFY_INTRUSION;
                                    notified_flag_next = 1'b0;
                                end
                                screen = SCREEN_INTRUSION;
                            end else begin
                                // Wrong PIN during intrusion: count up to three.
                                if (wrong_pin_count_reg != 2'd3) begin
                                    wrong_pin_count_next = wrong_pin_count_reg + 2'd1;
                                end
                                if (wrong_pin_count_next >= 2'd2) begin
                                    notify = NOTIFY_WRONG_PIN;
                                    screen = SCREEN_WARNED;
                                end else begin
                                    screen = SCREEN_RETRY;
                                end
                            end
                        end
                    end
                    CMD_NONE: begin
                    end
                    default: begin
                    end
                endcase
                // Motion is handled after the command, against the new state.
                if (item.violation && alarm_state_next == ST_ARMED) begin
                    alarm_state_next = ST_PRE;
                    entry_timer_next = '0;
                    led_red_next     = LED_FULL;
                    led_green_next   = LED_FULL;
                    led_blue_next    = LED_DARK;
                    screen           = SCREEN_MOTION;
                    if (!notified_flag_next) begin
                        notify             = NOTIFY_MOTION;
                        notified_flag_next = 1'b1;
                    end
                end
            end
            MODE_UNUSED: begin
            end
            default: begin
            end
        endcase

        // In intrusion the LED shows the clamped siren pulse in red.
        if (alarm_state_next == ST_INTR) begin
            if (pulse_level_next <= 10'sd0) begin
                led_red_next = LED_DARK;
            end else if (pulse_level_next >= PULSE_TOP) begin
                led_red_next = LED_FULL;
            end else begin
                led_red_next = pulse_level_next[7:0];
            end
            led_green_next = LED_DARK;
            led_blue_next  = LED_DARK;
        end
    end

    // Result of this item.
    assign result.system_state = alarm_state_next;
    assign result.led_red      = led_red_next;
    assign result.led_green    = led_green_next;
    assign result.led_blue     = led_blue_next;
    assign result.lamp_blink   = (alarm_state_next == ST_INTR);
    assign result.buzzer_on    = (alarm_state_next == ST_INTR) &&
                                 (pulse_level_next > BUZZER_LEVEL);
    assign result.notify_code  = notify;
    assign result.screen_code  = screen;

    // Panel state, updated once per item that moves to the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_state_reg     <= ST_OFF;
            entry_timer_reg     <= '0;
            wrong_pin_count_reg <= 2'd0;
            notified_flag_reg   <= 1'b0;
            pulse_level_reg     <= 10'sd0;
            pulse_falling_reg   <= 1'b0;
            pulse_prescaler_reg <= 8'd0;
            led_red_reg         <= LED_DARK;
            led_green_reg       <= LED_DARK;
            led_blue_reg        <= LED_DARK;
        end else if (en) begin
            alarm_state_reg     <= alarm_state_next;
            entry_timer_reg     <= entry_timer_next;
            wrong_pin_count_reg <= wrong_pin_count_next;
            notified_flag_reg   <= notified_flag_next;
            pulse_level_reg     <= pulse_level_next;
            pulse_falling_reg   <= pulse_falling_next;
            pulse_prescaler_reg <= pulse_prescaler_next;
            led_red_reg         <= led_red_next;
            led_green_reg       <= led_green_next;
            led_blue_reg        <= led_blue_next;
        end
    end

    // A tick never wakes a panel that is switched off.
    a_off_stays_off_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        en && alarm_state_reg == ST_OFF && item.mode == MODE_TICK
        |=> alarm_state_reg == ST_OFF)
        else $error("tick moved the panel out of the off state");

    // The entry timer only moves in pre-alarm or when pre-alarm is entered.
    a_timer_only_in_pre: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_state_reg != ST_PRE |=> alarm_state_reg == ST_PRE || $stable(entry_timer_reg))
        else $error("entry timer changed outside pre-alarm");

    // The siren pulse cannot move from off or armed within one item.
    a_pulse_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        alarm_state_reg == ST_OFF || alarm_state_reg == ST_ARMED
        |=> $stable(pulse_level_reg))
        else $error("siren pulse moved while off or armed");

endmodule

// ===== rtl/intrusion_alarm_controller.sv =====
// An accepted beat passes through the input register, then the result register,
// on to its result beat. Throughput: one beat per cycle while the output is not
// stalled; the panel update is one pass of logic per item.
// Reset (aresetn low at a clock edge): panel off, timers, counters and pulse cleared,
// LED dark, both pipeline stages empty, registers back to PIN 1981, delay 10000 ms,
// pulse period 5 and pulse step 5.
module intrusion_alarm_controller import iac_pkg::*; #(
    parameter int TIMER_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // command[1:0], pin_value[15:2], violation[16], zeros
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // system_state[1:0], led_red[9:2], led_green[17:10],
                                   // led_blue[25:18], lamp_blink[26], buzzer_on[27],
                                   // notify_code[29:28], screen_code[32:30], zeros
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    logic    in_valid_reg;
    item_t   item_reg;
    logic    m_tvalid_reg;
    logic [39:0] m_tdata_reg;
    cfg_t    cfg_reg;
    logic    advance;
    result_t result;

    // The head item moves on whenever the result register is free or being emptied.
    assign advance   = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.master_pin         <= MASTER_PIN_RESET;
            cfg_reg.entry_delay_ms     <= ENTRY_DELAY_RESET;
            cfg_reg.pulse_period_ticks <= PULSE_PERIOD_RESET;
            cfg_reg.pulse_step         <= PULSE_STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MASTER_PIN:   cfg_reg.master_pin         <= cfg_data[13:0];
                CFG_ENTRY_DELAY:  cfg_reg.entry_delay_ms     <= cfg_data;
                CFG_PULSE_PERIOD: cfg_reg.pulse_period_ticks <= cfg_data[7:0];
                CFG_PULSE_STEP:   cfg_reg.pulse_step         <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode      <= mode_t'(s_tuser);
            item_reg.command   <= command_t'(s_tdata[1:0]);
            item_reg.pin_value <= s_tdata[15:2];
            item_reg.violation <= s_tdata[16];
        end
    end

    iac_fsm #(
        .TIMER_BITS (TIMER_BITS)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // Result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (advance) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {7'd0, result.screen_code, result.notify_code, result.buzzer_on,
                            result.lamp_blink, result.led_blue, result.led_green,
                            result.led_red, result.system_state};
        end
    end

    // Every item that leaves the input stage shows up as a result beat.
    a_advance_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("item left the input stage without a result beat");

    // A held item in the input stage is never dropped.
    a_head_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg))
        else $error("stalled input item was lost or changed");

    // The input stage never takes a beat while full and blocked.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && m_tvalid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while the pipe was full");

endmodule

// ===== tb/sv/intrusion_alarm_controller_tb.sv =====
module intrusion_alarm_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iac_pkg::*;

    // Panel states as reported in the status beat.
    typedef enum logic [1:0] {
        PANEL_OFF       = 2'd0,
        PANEL_ARMED     = 2'd1,
        PANEL_PRE_ALARM = 2'd2,
        PANEL_INTRUSION = 2'd3
    } panel_t;

    localparam logic [19:0] TIMER_MAX  = 20'hFFFFF;
    localparam logic [1:0]  PIN_SATURATE = 2'd3;
    localparam int          STALL_LIMIT  = 2000;

    // Scoreboard: keeps its own copy of the panel and the status beats still owed.
    class panel_scoreboard;
        result_t     status_q[$];
        int          mismatches;
        int          beats_seen;

        logic [13:0] pin_code;
        logic [19:0] delay_ms;
        logic [7:0]  pulse_period;
        logic [6:0]  step_size;

        panel_t      panel;
        logic [19:0] entry_count;
        logic [1:0]  bad_pins;
        bit          notified;
        int          pulse_lvl;
        bit          pulse_down;
        logic [7:0]  prescale;
        logic [7:0]  led_r, led_g, led_b;
        logic [1:0]  step_notify;
        logic [2:0]  step_screen;

        function new();
            pin_code     = MASTER_PIN_RESET;
            delay_ms     = ENTRY_DELAY_RESET;
            pulse_period = PULSE_PERIOD_RESET;
            step_size    = PULSE_STEP_RESET;
            panel        = PANEL_OFF;
            entry_count  = '0;
            bad_pins     = '0;
            notified     = 1'b0;
            pulse_lvl    = 0;
            pulse_down   = 1'b0;
            prescale     = '0;
            led_r        = LED_DARK;
            led_g        = LED_DARK;
            led_b        = LED_DARK;
            mismatches   = 0;
            beats_seen   = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [19:0] val);
            case (idx)
                CFG_MASTER_PIN:   pin_code     = val[13:0];
                CFG_ENTRY_DELAY:  delay_ms     = val;
                CFG_PULSE_PERIOD: pulse_period = val[7:0];
                CFG_PULSE_STEP:   step_size    = val[6:0];
                default: ;
            endcase
        endfunction

        function void go_armed();
            panel    = PANEL_ARMED;
            notified = 1'b0;
            led_r    = LED_DARK;
            led_g    = LED_FULL;
            led_b    = LED_DARK;
        endfunction

        function void fire_intrusion();
            panel = PANEL_INTRUSION;
            led_r = LED_FULL;
            led_g = LED_DARK;
            led_b = LED_DARK;
            if (notified) begin
                step_notify = NOTIFY_INTRUSION;
                notified    = 1'b0;
            end
            step_screen = SCREEN_INTRUSION;
        endfunction

        // Triangle siren: move by one step and turn around at either end.
        function void step_pulse();
            pulse_lvl += pulse_down ? -int'(step_size) : int'(step_size);
            if (pulse_lvl > 511) pulse_lvl = 511;
            if (pulse_lvl < -512) pulse_lvl = -512;
            if (pulse_lvl >= 255 || pulse_lvl <= 0) pulse_down = !pulse_down;
        endfunction

        // Applies one event to the panel copy and returns the status it should report.
        function result_t advance_panel(item_t ev);
            result_t    r;
            logic [7:0] period_eff;
            step_notify = NOTIFY_NONE;
            step_screen = SCREEN_UNCHANGED;
            case (ev.mode)
                MODE_TICK: begin
                    if (panel == PANEL_PRE_ALARM) begin
                        if (entry_count != TIMER_MAX) entry_count = entry_count + 20'd1;
                        if (entry_count >= delay_ms) fire_intrusion();
                    end
                    if (panel == PANEL_INTRUSION) begin
                        period_eff = (pulse_period == 8'd0) ? 8'd1 : pulse_period;
                        prescale   = prescale + 8'd1;
                        if (prescale >= period_eff) begin
                            prescale = '0;
                            step_pulse();
                        end
                    end
                end
                MODE_BUTTON: begin
                    if (panel == PANEL_INTRUSION || panel == PANEL_PRE_ALARM) begin
                        go_armed();
                        step_screen = SCREEN_ARMED;
                    end
                end
                MODE_MESSAGE: begin
                    case (ev.command)
                        CMD_ACTIVATE: begin
                            go_armed();
                            step_screen = SCREEN_ARMED;
                        end
                        CMD_DEACTIVATE: begin
                            panel       = PANEL_OFF;
                            notified    = 1'b0;
                            led_r       = LED_DARK;
                            led_g       = LED_DARK;
                            led_b       = LED_DARK;
                            step_screen = SCREEN_DISARMED;
                        end
                        CMD_RESET_PIN: begin
                            if (panel == PANEL_INTRUSION || panel == PANEL_PRE_ALARM) begin
                                if (ev.pin_value == pin_code) begin
                                    go_armed();
                                    bad_pins    = '0;
                                    step_screen = SCREEN_GRANTED;
                                end else if (panel == PANEL_PRE_ALARM) begin
                                    fire_intrusion();
                                end else begin
                                    if (bad_pins != PIN_SATURATE) bad_pins = bad_pins + 2'd1;
                                    if (bad_pins >= 2'd2) begin
                                        step_notify = NOTIFY_WRONG_PIN;
                                        step_screen = SCREEN_WARNED;
                                    end else begin
                                        step_screen = SCREEN_RETRY;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                    // Motion is looked at only after the command has been applied.
                    if (ev.violation && panel == PANEL_ARMED) begin
                        panel       = PANEL_PRE_ALARM;
                        entry_count = '0;
                        led_r       = LED_FULL;
                        led_g       = LED_FULL;
                        led_b       = LED_DARK;
                        step_screen = SCREEN_MOTION;
                        if (!notified) begin
                            step_notify = NOTIFY_MOTION;
                            notified    = 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            // During intrusion the red channel follows the clamped siren level.
            if (panel == PANEL_INTRUSION) begin
                if (pulse_lvl <= 0) led_r = 8'd0;
                else if (pulse_lvl >= 255) led_r = 8'd255;
                else led_r = pulse_lvl[7:0];
                led_g = LED_DARK;
                led_b = LED_DARK;
            end

            r.system_state = panel;
            r.led_red      = led_r;
            r.led_green    = led_g;
            r.led_blue     = led_b;
            r.lamp_blink   = (panel == PANEL_INTRUSION);
            r.buzzer_on    = (panel == PANEL_INTRUSION) && (pulse_lvl > 150);
            r.notify_code  = step_notify;
            r.screen_code  = step_screen;
            return r;
        endfunction

        function void note_event(item_t ev);
            status_q.push_back(advance_panel(ev));
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        // Each mismatch prints one line and is counted.
        task report(input string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task cmp_field(input string name, input int unsigned got, input int unsigned want);
            if (got != want)
                report($sformatf("status beat %0d %s: got %0d, want %0d",
                                 beats_seen, name, got, want));
        endtask

        task check_result(input logic [39:0] beat);
            result_t want;
            beats_seen++;
            if (status_q.size() == 0) begin
                report($sformatf("status beat %0d arrived with nothing pending", beats_seen));
                return;
            end
            want = status_q.pop_front();
            cmp_field("system_state", beat[1:0],   want.system_state);
            cmp_field("led_red",      beat[9:2],   want.led_red);
            cmp_field("led_green",    beat[17:10], want.led_green);
            cmp_field("led_blue",     beat[25:18], want.led_blue);
            cmp_field("lamp_blink",   beat[26],    want.lamp_blink);
            cmp_field("buzzer_on",    beat[27],    want.buzzer_on);
            cmp_field("notify_code",  beat[29:28], want.notify_code);
            cmp_field("screen_code",  beat[32:30], want.screen_code);
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_data  = '0;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;

    panel_scoreboard sb = new();

    intrusion_alarm_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Receiver side: random backpressure at the current stall rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Every accepted status beat is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // Watchdog: ends the run if no channel moves a beat for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic item_t mk(mode_t m, command_t c, logic [13:0] p, logic v);
        item_t ev;
        ev.mode      = m;
        ev.command   = c;
        ev.pin_value = p;
        ev.violation = v;
        return ev;
    endfunction

    // Mostly ticks and messages; fields that a mode ignores stay random.
    function automatic item_t random_event();
        item_t ev;
        int    roll;
        ev.command   = command_t'($urandom_range(3));
        ev.pin_value = 14'($urandom_range(16383));
        ev.violation = 1'($urandom_range(1));
        roll = $urandom_range(99);
        if (roll < 50) ev.mode = MODE_TICK;
        else if (roll < 55) ev.mode = MODE_BUTTON;
        else if (roll < 60) ev.mode = MODE_UNUSED;
        else begin
            ev.mode = MODE_MESSAGE;
            roll = $urandom_range(99);
            if (roll < 20) ev.command = CMD_NONE;
            else if (roll < 40) ev.command = CMD_ACTIVATE;
            else if (roll < 50) ev.command = CMD_DEACTIVATE;
            else ev.command = CMD_RESET_PIN;
            if ($urandom_range(99) < 40) ev.pin_value = sb.pin_code;
            ev.violation = ($urandom_range(99) < 45);
        end
        return ev;
    endfunction

    // Sends one event beat; tvalid stays high when the next beat follows at once.
    task automatic push_event(input item_t ev);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ev.mode;
        s_tdata  <= {7'd0, ev.violation, ev.pin_value, ev.command};
        do @(posedge aclk); while (!s_tready);
        sb.note_event(ev);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    // Holds the sender off until every status beat owed has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register writes happen only with the panel idle; unused upper bits are random.
    task automatic set_panel(input logic [13:0] pin, input logic [19:0] delay,
                             input logic [7:0] period, input logic [6:0] step);
        settle();
        write_reg(CFG_MASTER_PIN,   {6'($urandom_range(63)), pin});
        write_reg(CFG_ENTRY_DELAY,  delay);
        write_reg(CFG_PULSE_PERIOD, {12'($urandom_range(4095)), period});
        write_reg(CFG_PULSE_STEP,   {13'($urandom_range(8191)), step});
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        item_t ev;
        int    sent;
        int    burst;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < count) begin
            ev = random_event();
            push_event(ev);
            sent++;
            // Runs of ticks let the entry timer expire and the siren climb.
            if (ev.mode == MODE_TICK && $urandom_range(3) == 0) begin
                burst = $urandom_range(30, 2);
                repeat (burst) begin
                    ev = random_event();
                    ev.mode = MODE_TICK;
                    push_event(ev);
                    sent++;
                end
            end
            if ($urandom_range(99) == 0) settle();
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed walk through the panel at reset register values.
        push_event(mk(MODE_TICK,    CMD_RESET_PIN,  14'h3FFF, 1'b1));
        push_event(mk(MODE_BUTTON,  CMD_ACTIVATE,   14'h0000, 1'b1));
        push_event(mk(MODE_UNUSED,  CMD_ACTIVATE,   14'h2AAA, 1'b1));
        push_event(mk(MODE_MESSAGE, CMD_NONE,       14'h0000, 1'b1));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  MASTER_PIN_RESET, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_ACTIVATE,   14'h0000, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  14'h0000, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_NONE,       14'h1555, 1'b1));
        push_event(mk(MODE_TICK,    CMD_NONE,       14'h0000, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  MASTER_PIN_RESET, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_ACTIVATE,   14'h0000, 1'b1));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  14'h3FFF, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  14'h0000, 1'b1));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  14'd9999, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  14'h0001, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  14'h2000, 1'b0));
        repeat (6) push_event(mk(MODE_TICK, CMD_DEACTIVATE, 14'h3FFF, 1'b1));
        push_event(mk(MODE_BUTTON,  CMD_DEACTIVATE, 14'h0000, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_NONE,       14'h0000, 1'b1));
        push_event(mk(MODE_MESSAGE, CMD_RESET_PIN,  MASTER_PIN_RESET, 1'b0));
        push_event(mk(MODE_MESSAGE, CMD_DEACTIVATE, 14'h0000, 1'b1));

        // Random phases over several register settings and idling patterns.
        set_panel(14'd0, 20'd1, 8'd1, 7'd64);
        run_random(160, 0, 0);
        set_panel(14'h3FFF, 20'd0, 8'd0, 7'd127);
        run_random(150, 50, 0);
        set_panel(14'd9999, 20'hFFFFF, 8'd255, 7'd1);
        run_random(140, 0, 50);
        set_panel(14'($urandom_range(16383)), 20'($urandom_range(12, 1)),
                  8'($urandom_range(6, 1)), 7'($urandom_range(64, 1)));
        run_random(160, 7, 7);
        set_panel(14'($urandom_range(16383)), 20'd2, 8'd2, 7'd0);
        run_random(150, 50, 50);
        set_panel(14'($urandom_range(16383)), 20'($urandom_range(20, 1)),
                  8'($urandom_range(4, 1)), 7'($urandom_range(64, 1)));
        run_random(170, 0, 0);

        settle();
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== intrusion_alarm_controller.f =====
rtl/iac_pkg.sv
rtl/iac_fsm.sv
rtl/intrusion_alarm_controller.sv
tb/sv/intrusion_alarm_controller_tb.sv
